// ===== hdl/ppmd_pkg.sv =====
package ppmd_pkg;

  localparam int CH_W     = 3;
  localparam int MAX_CH   = 8;
  localparam int VAL_W    = 12;
  localparam int TIME_W   = 16;
  localparam int ORDER_W  = 24;
  localparam int CNT_W    = 4;
  localparam int HIST_D   = 4;
  localparam int SLOT_W   = 2;
  localparam int SUM_W    = VAL_W + SLOT_W;
  localparam int ROW_W    = VAL_W * (HIST_D + 1);
  localparam int IDX_W    = 8;

  localparam logic [CNT_W-1:0]   COUNT_SAT = 4'd8;
  localparam logic [VAL_W-1:0]   RAW_RESET = 12'd1502;
  localparam logic [VAL_W-1:0]   VAL_MAX   = 12'd4095;

  localparam logic [TIME_W-1:0]  SYNC_GAP_RESET  = 16'd3000;
  localparam logic [TIME_W-1:0]  PULSE_MIN_RESET = 16'd900;
  localparam logic [TIME_W-1:0]  PULSE_MAX_RESET = 16'd2200;
  localparam logic [ORDER_W-1:0] ORDER_RESET     = 24'd16434824;

  localparam logic [IDX_W-1:0] REG_SYNC_GAP  = 8'd0;
  localparam logic [IDX_W-1:0] REG_PULSE_MIN = 8'd1;
  localparam logic [IDX_W-1:0] REG_PULSE_MAX = 8'd2;
  localparam logic [IDX_W-1:0] REG_CH_ORDER  = 8'd3;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  sync_gap;
    logic [TIME_W-1:0]  pulse_min;
    logic [TIME_W-1:0]  pulse_max;
    logic [ORDER_W-1:0] channel_order;
  } ppmd_cfg_t;

endpackage

// ===== hdl/ppmd_item_if.sv =====
interface ppmd_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] edge_time;

  modport source (output valid, kind, edge_time, input ready);
  modport sink (input valid, kind, edge_time, output ready);
endinterface

// ===== hdl/ppmd_result_if.sv =====
interface ppmd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel;
  logic [11:0] filtered_value;
  logic        last;

  modport source (output valid, channel, filtered_value, last, input ready);
  modport sink (input valid, channel, filtered_value, last, output ready);
endinterface

// ===== hdl/ppmd_cfg_if.sv =====
interface ppmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ppm_sum_decoder_with_rc_filter.sv =====
// ppm sum decoder with four-sample mean and deadband filter
//
// item channel: kind 0 is a signal edge with a microsecond timestamp, kind 1
// is a filter tick. an edge word is absorbed and gives no result. a tick
// word produces NUM_CHANNELS result words, channel 0 first, last set on
// the final one.
// result channel: registered output. first result of a tick passes the
// issue state, the ram read stage and the output register; then one result
// per cycle while the receiver takes them. a tick holds item ready low
// until its last channel has left the read stage. the per-channel history
// and filtered value live in one row of the channel-state ram, read by the
// read stage, written back as it moves on: one read, one write per channel.
// a stalled receiver holds the output word; the read pipe stops and the
// ram read data is held until the output frees up.
// cfg channel: always ready; write only while no tick is in progress.
// index 0 sync_gap, 1 pulse_min, 2 pulse_max, 3 channel_order.
// reset (synchronous) restores the register defaults, sets every raw width
// to 1502 and marks all ram rows empty, so history and filtered values read
// as zero; no clearing pass is needed.
module ppm_sum_decoder_with_rc_filter #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst,
  ppmd_item_if.sink     item,
  ppmd_result_if.source result,
  ppmd_cfg_if.sink      cfg
);
  import ppmd_pkg::*;

  ppmd_cfg_t        cfg_regs;
  logic             busy;
  logic             item_fire;
  logic [CH_W-1:0]  raw_sel;
  logic [VAL_W-1:0] raw_width;

  assign cfg.ready  = 1'b1;
  assign item.ready = !busy;
  assign item_fire  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sync_gap      <= SYNC_GAP_RESET;
      cfg_regs.pulse_min     <= PULSE_MIN_RESET;
      cfg_regs.pulse_max     <= PULSE_MAX_RESET;
      cfg_regs.channel_order <= ORDER_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SYNC_GAP:  cfg_regs.sync_gap      <= cfg.data[TIME_W-1:0];
        REG_PULSE_MIN: cfg_regs.pulse_min     <= cfg.data[TIME_W-1:0];
        REG_PULSE_MAX: cfg_regs.pulse_max     <= cfg.data[TIME_W-1:0];
        REG_CH_ORDER:  cfg_regs.channel_order <= cfg.data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  ppmd_edge #(.NUM_CHANNELS(NUM_CHANNELS)) u_edge (
    .clk       (clk),
    .rst       (rst),
    .edge_fire (item_fire && item.kind == KIND_EDGE),
    .edge_time (item.edge_time),
    .cfg       (cfg_regs),
    .raw_sel   (raw_sel),
    .raw_width (raw_width)
  );

  ppmd_filter #(.NUM_CHANNELS(NUM_CHANNELS)) u_filter (
    .clk           (clk),
    .rst           (rst),
    .tick_start    (item_fire && item.kind == KIND_TICK),
    .channel_order (cfg_regs.channel_order),
    .raw_sel       (raw_sel),
    .raw_width     (raw_width),
    .busy          (busy),
    .result        (result)
  );

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last |-> result.channel == CH_W'(NUM_CHANNELS - 1))
    else $error("last flag on wrong channel");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.kind == KIND_TICK |=> !item.ready)
    else $error("item taken during tick");

  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.kind == KIND_TICK |->
      !result.valid || result.last)
    else $error("tick started with results of the previous tick pending");

endmodule

// ===== hdl/ppmd_ram.sv =====
module ppmd_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ppmd_edge.sv =====
module ppmd_edge #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      edge_fire,
  input  logic [15:0]               edge_time,
  input  ppmd_pkg::ppmd_cfg_t       cfg,
  input  logic [ppmd_pkg::CH_W-1:0] raw_sel,
  output logic [11:0]               raw_width
);
  import ppmd_pkg::*;

  logic [TIME_W-1:0] prev_time;
  logic [CNT_W-1:0]  counter;
  logic [VAL_W-1:0]  raw [MAX_CH];
  logic [TIME_W-1:0] gap;
  logic [VAL_W-1:0]  gap_sat;
  logic              is_sync;
  logic              store;

  assign gap     = edge_time - prev_time;
  assign gap_sat = (gap[TIME_W-1:VAL_W] != '0) ? VAL_MAX : gap[VAL_W-1:0];
  assign is_sync = gap > cfg.sync_gap;
  assign store   = !is_sync && gap > cfg.pulse_min && gap < cfg.pulse_max &&
                   counter < CNT_W'(NUM_CHANNELS);
  assign raw_width = raw[raw_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      counter   <= '0;
      for (int i = 0; i < MAX_CH; i++) begin
        raw[i] <= RAW_RESET;
      end
    end else if (edge_fire) begin
      prev_time <= edge_time;
      if (is_sync) begin
        counter <= '0;
      end else if (counter < COUNT_SAT) begin
        counter <= counter + 1'b1;
      end
      if (store) begin
        raw[counter[CH_W-1:0]] <= gap_sat;
      end
    end
  end

endmodule

// ===== hdl/ppmd_filter.sv =====
module ppmd_filter #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_start,
  input  logic [ppmd_pkg::ORDER_W-1:0] channel_order,
  output logic [ppmd_pkg::CH_W-1:0]    raw_sel,
  input  logic [11:0]                  raw_width,
  output logic                         busy,
  ppmd_result_if.source                result
);
  import ppmd_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  logic              issuing;
  logic [CH_W-1:0]   issue_ch;
  logic [SLOT_W-1:0] slot;
  logic              s1_valid;
  logic [CH_W-1:0]   s1_ch;
  logic [VAL_W-1:0]  s1_raw;
  logic              s1_row_ok;
  logic [MAX_CH-1:0] row_valid;
  logic              s1_go;
  logic              issue_fire;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [VAL_W-1:0]  hist [HIST_D];
  logic [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]  mean;
  logic [VAL_W-1:0]  cur;
  logic [VAL_W-1:0]  filt_next;

  assign busy       = issuing || s1_valid;
  assign s1_go      = s1_valid && (!result.valid || result.ready);
  // read only when the stage behind can take the row next cycle
  assign issue_fire = issuing && (!s1_valid || s1_go);
  assign raw_sel    = channel_order[3 * issue_ch +: CH_W];

  ppmd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CH)) u_rows (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_ch),
    .wdata (row_next),
    .re    (issue_fire),
    .raddr (issue_ch),
    .rdata (rd_row)
  );

  // rows never written read as zero
  assign row = s1_row_ok ? rd_row : '0;

  always_comb begin
    for (int a = 0; a < HIST_D; a++) begin
      hist[a] = row[a*VAL_W +: VAL_W];
    end
    hist[slot] = s1_raw;
    sum = '0;
    for (int a = 0; a < HIST_D; a++) begin
      sum = sum + SUM_W'(hist[a]);
    end
    mean = VAL_W'((sum + SUM_W'(2)) >> SLOT_W);
    cur  = row[HIST_D*VAL_W +: VAL_W];
    if ({1'b0, mean} + 13'd3 < {1'b0, cur}) begin
      filt_next = mean + VAL_W'(2);
    end else if ({1'b0, mean} > {1'b0, cur} + 13'd3) begin
      filt_next = mean - VAL_W'(2);
    end else begin
      filt_next = cur;
    end
    for (int a = 0; a < HIST_D; a++) begin
      row_next[a*VAL_W +: VAL_W] = hist[a];
    end
    row_next[HIST_D*VAL_W +: VAL_W] = filt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing      <= 1'b0;
      issue_ch     <= '0;
      slot         <= '0;
      s1_valid     <= 1'b0;
      row_valid    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (tick_start) begin
        issuing  <= 1'b1;
        issue_ch <= '0;
        slot     <= slot + 1'b1;
      end else if (issue_fire) begin
        if (issue_ch == LAST_CH) begin
          issuing <= 1'b0;
        end else begin
          issue_ch <= issue_ch + 1'b1;
        end
      end
      if (issue_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        row_valid[s1_ch] <= 1'b1;
        result.valid     <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_fire) begin
      s1_ch     <= issue_ch;
      s1_raw    <= raw_width;
      s1_row_ok <= row_valid[issue_ch];
    end
    if (s1_go) begin
      result.channel        <= s1_ch;
      result.filtered_value <= filt_next;
      result.last           <= (s1_ch == LAST_CH);
    end
  end

endmodule
